FILE: rtl/acqf_pkg.sv
// acqf_pkg: shared types, codes and constants of the audio command queue framer
// no dependencies; imported by acqf_framer and audio_command_queue_framer
`timescale 1ns / 1ps
`default_nettype none

package acqf_pkg;

  // fifo depth default (ring holds one entry less than this)
  localparam int ACQF_FIFO_DEPTH = 16;

  // reset value of the minimum gap register, in milliseconds
  localparam logic [15:0] ACQF_GAP_RESET = 16'd50;

  // field widths
  localparam int CMD_W   = 8;
  localparam int PARAM_W = 16;
  localparam int ENTRY_W = CMD_W + PARAM_W;
  localparam int TIME_W  = 32;
  localparam int GAP_W   = 16;

  // request kinds carried in s_tuser
  typedef enum logic [1:0] {
    REQ_ENQUEUE = 2'd0,
    REQ_FORCE   = 2'd1,
    REQ_TICK    = 2'd2,
    REQ_UNUSED  = 2'd3
  } acqf_req_t;

  // control sequencer states
  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_READ = 1'b1
  } acqf_state_t;

  // frame start request from the queue control to the framer
  typedef struct packed {
    logic               start;
    logic [ENTRY_W-1:0] entry;
  } acqf_frame_req_t;

  // register map
  localparam int APB_DATA_W = 32;
  localparam int PADDR_W    = 3;
  localparam logic [0:0] REG_MIN_GAP = 1'b0;

endpackage

`default_nettype wire

FILE: rtl/acqf_ram.sv
// acqf_ram: generic single-write, single-read synchronous ram, registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module acqf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/acqf_framer.sv
// acqf_framer: turns one queue entry into the ten-byte command frame, one beat a byte
// depends on acqf_pkg
`timescale 1ns / 1ps
`default_nettype none

module acqf_framer
  import acqf_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire acqf_frame_req_t req,
  output logic                 busy,
  output logic                 m_tvalid,
  input  wire logic            m_tready,
  output logic [7:0]           m_tdata,   // frame_byte[7:0]
  output logic                 m_tlast    // last_byte
);

  localparam logic [3:0] POS_SOF   = 4'd0;
  localparam logic [3:0] POS_VER   = 4'd1;
  localparam logic [3:0] POS_LEN   = 4'd2;
  localparam logic [3:0] POS_CMD   = 4'd3;
  localparam logic [3:0] POS_FB    = 4'd4;
  localparam logic [3:0] POS_PH    = 4'd5;
  localparam logic [3:0] POS_PL    = 4'd6;
  localparam logic [3:0] POS_CKH   = 4'd7;
  localparam logic [3:0] POS_CKL   = 4'd8;
  localparam logic [3:0] POS_END   = 4'd9;

  localparam logic [7:0] BYTE_SOF = 8'h7E;
  localparam logic [7:0] BYTE_VER = 8'hFF;
  localparam logic [7:0] BYTE_LEN = 8'h06;
  localparam logic [7:0] BYTE_FB  = 8'h00;
  localparam logic [7:0] BYTE_END = 8'hEF;

  logic [3:0]         pos;
  logic [ENTRY_W-1:0] entry_q;
  logic [15:0]        ck_q;
  logic [15:0]        sum;
  logic [3:0]         pos_next;
  logic [7:0]         byte_next;
  logic               beat;

  // constant bytes ff + 06, plus the entry bytes
  assign sum = 16'({8'h00, BYTE_VER}) + 16'({8'h00, BYTE_LEN}) + 16'({8'h00, BYTE_FB})
             + 16'({8'h00, req.entry[23:16]}) + 16'({8'h00, req.entry[15:8]})
             + 16'({8'h00, req.entry[7:0]});

  assign beat     = m_tvalid && m_tready;
  assign pos_next = pos + 4'd1;

  always_comb begin
    case (pos_next)
      POS_SOF: byte_next = BYTE_SOF;
      POS_VER: byte_next = BYTE_VER;
      POS_LEN: byte_next = BYTE_LEN;
      POS_CMD: byte_next = entry_q[23:16];
      POS_FB:  byte_next = BYTE_FB;
      POS_PH:  byte_next = entry_q[15:8];
      POS_PL:  byte_next = entry_q[7:0];
      POS_CKH: byte_next = ck_q[15:8];
      POS_CKL: byte_next = ck_q[7:0];
      default: byte_next = BYTE_END;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      pos      <= POS_SOF;
    end else if (req.start) begin
      m_tvalid <= 1'b1;
      pos      <= POS_SOF;
      m_tdata  <= BYTE_SOF;
      entry_q  <= req.entry;
      ck_q     <= 16'h0000 - sum;
    end else if (beat) begin
      if (pos == POS_END) begin
        m_tvalid <= 1'b0;
      end else begin
        pos     <= pos_next;
        m_tdata <= byte_next;
      end
    end
  end

  assign m_tlast = (pos == POS_END);
  assign busy    = m_tvalid;

endmodule

`default_nettype wire

FILE: rtl/audio_command_queue_framer.sv
// audio_command_queue_framer: command ring fifo with priority slot and frame output
// depends on acqf_pkg, acqf_ram, acqf_framer
//
//  channel  | dir | handshake           | payload
//  ---------+-----+---------------------+---------------------------------------------
//  s_axis   | in  | s_tvalid / s_tready | tuser = req_type, tdata = code, param, time, ready
//  m_axis   | out | m_tvalid / m_tready | tdata = frame_byte, tlast = last_byte
//  apb      | in  | psel/penable/pready | min_gap_ms at byte address 0
//
// enqueue, force and non-sending tick beats need no ram read and leave the sequencer idle
// a tick that sends the forced command starts the frame at once; a tick that sends the
// fifo head starts it from the read state after the ram read, then the frame runs ten output beats
// s_tready stays low while a frame is being shifted out, so a stalled m_tready holds input
// synchronous active-high reset clears pointers, the forced slot and the send time;
// the fifo ram itself is not cleared and is only read below the fill level
`timescale 1ns / 1ps
`default_nettype none

module audio_command_queue_framer
  import acqf_pkg::*;
#(
  parameter int FIFO_DEPTH = ACQF_FIFO_DEPTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // input stream
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [63:0]           s_tdata,   // command_code[7:0], command_param[23:8],
                                                // now_ms[55:24], player_ready[56], zero pad
  input  wire logic [1:0]            s_tuser,   // req_type[1:0]
  // output stream
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [7:0]                 m_tdata,   // frame_byte[7:0]
  output logic                       m_tlast,   // last_byte
  // configuration
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [PADDR_W-1:0]    paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0]      prdata,
  output logic                       pready
);

  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

  // unpacked input beat
  logic [CMD_W-1:0]   in_code;
  logic [PARAM_W-1:0] in_param;
  logic [TIME_W-1:0]  in_now;
  logic               in_ready;
  acqf_req_t          in_kind;
  logic [ENTRY_W-1:0] in_entry;

  assign in_code  = s_tdata[7:0];
  assign in_param = s_tdata[23:8];
  assign in_now   = s_tdata[55:24];
  assign in_ready = s_tdata[56];
  assign in_kind  = acqf_req_t'(s_tuser);
  assign in_entry = {in_code, in_param};

  // state registers
  acqf_state_t        state;
  acqf_state_t        state_next;
  logic [PTR_W-1:0]   wp;
  logic [PTR_W-1:0]   rp;
  logic [TIME_W-1:0]  last_send;
  logic               forced_pending;
  logic [ENTRY_W-1:0] forced_entry;
  logic [GAP_W-1:0]   min_gap;

  // control
  logic               accept;
  logic               framer_busy;
  logic [PTR_W-1:0]   wp_inc;
  logic [PTR_W-1:0]   rp_inc;
  logic               fifo_full;
  logic               fifo_empty;
  logic [TIME_W-1:0]  elapsed;
  logic               gap_ok;
  logic               do_enqueue;
  logic               do_force;
  logic               tick_go;
  logic               send_forced;
  logic               send_head;
  logic [ENTRY_W-1:0] ram_rdata;
  acqf_frame_req_t    frame_req;
  logic               cfg_write;

  assign wp_inc     = (wp == PTR_LAST) ? '0 : wp + PTR_W'(1);
  assign rp_inc     = (rp == PTR_LAST) ? '0 : rp + PTR_W'(1);
  assign fifo_full  = (wp_inc == rp);
  assign fifo_empty = (wp == rp);
  // wrapping difference, compared against the zero-extended gap
  assign elapsed    = in_now - last_send;
  assign gap_ok     = !(elapsed < {{(TIME_W-GAP_W){1'b0}}, min_gap});

  assign accept      = s_tvalid && s_tready;
  assign do_enqueue  = accept && (in_kind == REQ_ENQUEUE) && !fifo_full;
  assign do_force    = accept && (in_kind == REQ_FORCE);
  // tick records the time once work is pending and the gap has passed
  assign tick_go     = accept && (in_kind == REQ_TICK)
                     && (!fifo_empty || forced_pending) && gap_ok;
  assign send_forced = tick_go && forced_pending;
  assign send_head   = tick_go && !forced_pending && in_ready;

  // next-state logic
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (send_head) begin
          state_next = ST_READ;
        end
      end
      ST_READ: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // output logic
  always_comb begin
    s_tready        = 1'b0;
    frame_req.start = 1'b0;
    frame_req.entry = forced_entry;
    case (state)
      ST_IDLE: begin
        s_tready        = !framer_busy;
        frame_req.start = send_forced;
      end
      ST_READ: begin
        // ram data for the head is valid in the cycle after the tick
        frame_req.start = 1'b1;
        frame_req.entry = ram_rdata;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      wp             <= '0;
      rp             <= '0;
      last_send      <= '0;
      forced_pending <= 1'b0;
      forced_entry   <= '0;
    end else begin
      state <= state_next;
      if (do_enqueue) begin
        wp <= wp_inc;
      end
      if (state == ST_READ) begin
        rp <= rp_inc;
      end
      if (tick_go) begin
        last_send <= in_now;
      end
      if (do_force) begin
        forced_pending <= 1'b1;
        forced_entry   <= in_entry;
      end else if (send_forced) begin
        forced_pending <= 1'b0;
      end
    end
  end

  // configuration port, register index in paddr above the byte offset
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr[PADDR_W-1:2] == REG_MIN_GAP);

  always_ff @(posedge clk) begin
    if (rst) begin
      min_gap <= ACQF_GAP_RESET;
    end else if (cfg_write) begin
      min_gap <= pwdata[GAP_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[PADDR_W-1:2] == REG_MIN_GAP) begin
      prdata = {{(APB_DATA_W-GAP_W){1'b0}}, min_gap};
    end
  end

  // fifo storage, read port parked on the head
  acqf_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo_ram (
    .clk   (clk),
    .we    (do_enqueue),
    .waddr (wp),
    .wdata (in_entry),
    .raddr (rp),
    .rdata (ram_rdata)
  );

  acqf_framer u_framer (
    .clk      (clk),
    .rst      (rst),
    .req      (frame_req),
    .busy     (framer_busy),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

`default_nettype wire

FILE: rtl/acqf_checker.sv
// acqf_checker: port-level assertions for the audio command queue framer
// depends on nothing; bound to audio_command_queue_framer
`timescale 1ns / 1ps
`default_nettype none

module acqf_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       s_tready,
  input wire logic       m_tvalid,
  input wire logic       m_tready,
  input wire logic [7:0] m_tdata,
  input wire logic       m_tlast
);

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output beat changed while stalled");

  // no input is taken while a frame is being sent
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input ready during frame output");

  // the closing beat carries the end byte
  a_end_byte: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata == 8'hEF)
    else $error("last beat is not the end byte");

  // frames never run back to back
  a_frame_gap: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tlast |=> !m_tvalid)
    else $error("output valid right after last beat");

  // reset empties the output
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind audio_command_queue_framer acqf_checker u_acqf_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

`default_nettype wire
